// ===== hdl/rbpw_pkg.sv =====
`timescale 1ns / 1ps

package rbpw_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int CNT_W        = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
    localparam int ATAN_IDX_W   = $clog2(ATAN_LEN);

    localparam int COORD_W   = 32;
    localparam int GAIN_W    = 20;
    localparam int NOISE_W   = 16;
    localparam int G_W       = 18;
    localparam int CFG_IDX_W = 2;

    localparam int P_SHIFT  = FRAC_BITS - 8;
    localparam int P_W      = GAIN_W + G_W - P_SHIFT;
    localparam int RZ_SHIFT = 16;
    localparam int COR_W    = 34;
    localparam int MUL_W    = (P_W > COR_W) ? P_W : COR_W;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int COS_FRAC = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_SPIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = CFG_IDX_W'(2);

    localparam logic signed [GAIN_W-1:0] SPIN_RESET   = GAIN_W'(314);
    localparam logic signed [GAIN_W-1:0] ZOOM_RESET   = GAIN_W'(0);
    localparam logic signed [GAIN_W-1:0] WEIGHT_RESET = GAIN_W'(65536);

    localparam logic [NOISE_W-1:0] NOISE_RESET = NOISE_W'(32768);
    localparam logic [G_W:0]       NOISE_BIAS  = (G_W + 1)'(131072);

    localparam logic [31:0] CORDIC_K   = 32'd652032874;
    localparam logic [31:0] INV_TWO_PI = 32'd42722830;
    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COR_W-1:0]  cor_t;

    localparam prod_t RND_COS  = prod_t'(1) <<< (COS_FRAC - 1);
    localparam prod_t RND_FRAC = prod_t'(1) <<< (FRAC_BITS - 1);
    localparam prod_t RZ_ONE   = prod_t'(1) <<< FRAC_BITS;
    localparam prod_t SAT_HI   = prod_t'(2147483647);
    localparam prod_t SAT_LO   = -SAT_HI - prod_t'(1);

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic    done;
        mul_op_t cos_val;
        mul_op_t sin_val;
    } cordic_rsp_t;

endpackage

// ===== hdl/radial_blur_point_warp_top.sv =====
`timescale 1ns / 1ps

// Radial blur point warp.
// Input channel (in_valid/in_ready): one transaction carries command, the
// point in_x/in_y/in_z, the accumulators acc_x/acc_y/acc_z and a noise
// sample. Every transaction pushes noise into the four-entry noise ring.
// A seed command (command = 1) does only that, with no result.
// A transform command produces one result transaction on out_valid/out_ready:
// out_x/out_y/out_z and clipped. out_valid rises after three gain and angle
// products plus the CORDIC load, the CORDIC rotation, seven passes through
// the shared multiplier and accumulator, and a saturating step; in_ready
// rises with it, so a new point is accepted only once the last is through.
// The result sits in an output register: a new point is accepted while it
// waits, and its final cycle holds until the older result is taken.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 spin_gain,
// 1 zoom_gain, 2 weight; index 3 is ignored. Write only while idle.
// Reset: gains return to 314 / 0 / 65536, the ring to all 0.5, no result.

module radial_blur_point_warp_top
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [rbpw_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rbpw_pkg::GAIN_W-1:0]             cfg_data,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    command,
    input  logic signed [rbpw_pkg::COORD_W-1:0]     in_x,
    input  logic signed [rbpw_pkg::COORD_W-1:0]     in_y,
    input  logic signed [rbpw_pkg::COORD_W-1:0]     in_z,
    input  logic signed [rbpw_pkg::COORD_W-1:0]     acc_x,
    input  logic signed [rbpw_pkg::COORD_W-1:0]     acc_y,
    input  logic signed [rbpw_pkg::COORD_W-1:0]     acc_z,
    input  logic [rbpw_pkg::NOISE_W-1:0]            noise,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [rbpw_pkg::COORD_W-1:0]     out_x,
    output logic signed [rbpw_pkg::COORD_W-1:0]     out_y,
    output logic signed [rbpw_pkg::COORD_W-1:0]     out_z,
    output logic                                    clipped
);

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_SG   = 14'b00000000000010,
        ST_ZG   = 14'b00000000000100,
        ST_TURN = 14'b00000000001000,
        ST_ANG  = 14'b00000000010000,
        ST_ROT  = 14'b00000000100000,
        ST_XC   = 14'b00000001000000,
        ST_YS   = 14'b00000010000000,
        ST_XS   = 14'b00000100000000,
        ST_YC   = 14'b00001000000000,
        ST_RX   = 14'b00010000000000,
        ST_RY   = 14'b00100000000000,
        ST_WZ   = 14'b01000000000000,
        ST_FIN  = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic signed [rbpw_pkg::COORD_W-1:0] value;
        logic                                clip;
    } sat_t;

    state_t                                  state_reg;
    state_t                                  state_next;

    logic signed [rbpw_pkg::GAIN_W-1:0]      spin_gain_reg;
    logic signed [rbpw_pkg::GAIN_W-1:0]      zoom_gain_reg;
    logic signed [rbpw_pkg::GAIN_W-1:0]      weight_reg;

    logic signed [rbpw_pkg::COORD_W-1:0]     x_reg;
    logic signed [rbpw_pkg::COORD_W-1:0]     y_reg;
    logic signed [rbpw_pkg::COORD_W-1:0]     z_reg;
    logic signed [rbpw_pkg::COORD_W-1:0]     ax_reg;
    logic signed [rbpw_pkg::COORD_W-1:0]     ay_reg;
    logic signed [rbpw_pkg::COORD_W-1:0]     az_reg;
    logic signed [rbpw_pkg::G_W-1:0]         g_reg;

    rbpw_pkg::mul_op_t                       p_reg;
    rbpw_pkg::mul_op_t                       rz_reg;
    rbpw_pkg::prod_t                         t0_reg;
    rbpw_pkg::prod_t                         rx_reg;
    rbpw_pkg::prod_t                         ry_reg;
    rbpw_pkg::prod_t                         sx_reg;
    rbpw_pkg::prod_t                         sy_reg;

    logic                                    out_valid_reg;
    logic signed [rbpw_pkg::COORD_W-1:0]     out_x_reg;
    logic signed [rbpw_pkg::COORD_W-1:0]     out_y_reg;
    logic signed [rbpw_pkg::COORD_W-1:0]     out_z_reg;
    logic                                    clipped_reg;

    logic                                    in_fire;
    logic                                    out_free;
    logic signed [rbpw_pkg::G_W-1:0]         ring_g;
    rbpw_pkg::mul_op_t                       mul_a;
    rbpw_pkg::mul_op_t                       mul_b;
    rbpw_pkg::prod_t                         prod;
    rbpw_pkg::prod_t                         prod_rnd;
    rbpw_pkg::prod_t                         sz_next;
    rbpw_pkg::cordic_req_t                   cor_req;
    rbpw_pkg::cordic_rsp_t                   cor_rsp;
    sat_t                                    sat_x;
    sat_t                                    sat_y;
    sat_t                                    sat_z;

    function automatic sat_t sat32(input rbpw_pkg::prod_t v);
        sat_t r;
        if (v > rbpw_pkg::SAT_HI)
        begin
            r.value = rbpw_pkg::COORD_W'(rbpw_pkg::SAT_HI);
            r.clip  = 1'b1;
        end
        else if (v < rbpw_pkg::SAT_LO)
        begin
            r.value = rbpw_pkg::COORD_W'(rbpw_pkg::SAT_LO);
            r.clip  = 1'b1;
        end
        else
        begin
            r.value = rbpw_pkg::COORD_W'(v);
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    rbpw_ring u_ring
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_fire),
        .noise (noise),
        .g     (ring_g)
    );

    rbpw_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cor_req.start = (state_reg == ST_ANG);
    assign cor_req.angle = prod[51:20];

    rbpw_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .rsp   (cor_rsp)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_SG:
            begin
                mul_a = rbpw_pkg::MUL_W'(spin_gain_reg);
                mul_b = rbpw_pkg::MUL_W'(g_reg);
            end
            ST_ZG:
            begin
                mul_a = rbpw_pkg::MUL_W'(zoom_gain_reg);
                mul_b = rbpw_pkg::MUL_W'(g_reg);
            end
            ST_TURN:
            begin
                mul_a = p_reg;
                mul_b = rbpw_pkg::MUL_W'(rbpw_pkg::INV_TWO_PI);
            end
            ST_XC:
            begin
                mul_a = rbpw_pkg::MUL_W'(x_reg);
                mul_b = cor_rsp.cos_val;
            end
            ST_YS:
            begin
                mul_a = rbpw_pkg::MUL_W'(y_reg);
                mul_b = cor_rsp.sin_val;
            end
            ST_XS:
            begin
                mul_a = rbpw_pkg::MUL_W'(x_reg);
                mul_b = cor_rsp.sin_val;
            end
            ST_YC:
            begin
                mul_a = rbpw_pkg::MUL_W'(y_reg);
                mul_b = cor_rsp.cos_val;
            end
            ST_RX:
            begin
                mul_a = rz_reg;
                mul_b = rbpw_pkg::MUL_W'(x_reg);
            end
            ST_RY:
            begin
                mul_a = rz_reg;
                mul_b = rbpw_pkg::MUL_W'(y_reg);
            end
            ST_WZ, ST_FIN:
            begin
                mul_a = rbpw_pkg::MUL_W'(weight_reg);
                mul_b = rbpw_pkg::MUL_W'(z_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_rnd = (prod + rbpw_pkg::RND_FRAC) >>> rbpw_pkg::FRAC_BITS;
    assign sz_next  = rbpw_pkg::PROD_W'(az_reg) + prod_rnd;
    assign sat_x    = sat32(sx_reg);
    assign sat_y    = sat32(sy_reg);
    assign sat_z    = sat32(sz_next);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !command)
                begin
                    state_next = ST_SG;
                end
            end
            ST_SG:   state_next = ST_ZG;
            ST_ZG:   state_next = ST_TURN;
            ST_TURN: state_next = ST_ANG;
            ST_ANG:  state_next = ST_ROT;
            ST_ROT:
            begin
                if (cor_rsp.done)
                begin
                    state_next = ST_XC;
                end
            end
            ST_XC:   state_next = ST_YS;
            ST_YS:   state_next = ST_XS;
            ST_XS:   state_next = ST_YC;
            ST_YC:   state_next = ST_RX;
            ST_RX:   state_next = ST_RY;
            ST_RY:   state_next = ST_WZ;
            ST_WZ:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            spin_gain_reg <= rbpw_pkg::SPIN_RESET;
            zoom_gain_reg <= rbpw_pkg::ZOOM_RESET;
            weight_reg    <= rbpw_pkg::WEIGHT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rbpw_pkg::CFG_SPIN:   spin_gain_reg <= cfg_data;
                    rbpw_pkg::CFG_ZOOM:   zoom_gain_reg <= cfg_data;
                    rbpw_pkg::CFG_WEIGHT: weight_reg    <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg  <= in_x;
            y_reg  <= in_y;
            z_reg  <= in_z;
            ax_reg <= acc_x;
            ay_reg <= acc_y;
            az_reg <= acc_z;
            g_reg  <= ring_g;
        end
        case (state_reg)
            ST_ZG:   p_reg  <= rbpw_pkg::MUL_W'(prod >>> rbpw_pkg::P_SHIFT);
            ST_TURN: rz_reg <= rbpw_pkg::MUL_W'((prod >>> rbpw_pkg::RZ_SHIFT)
                                                - rbpw_pkg::RZ_ONE);
            ST_YS:   t0_reg <= prod + rbpw_pkg::RND_COS;
            ST_XS:   rx_reg <= (t0_reg - prod) >>> rbpw_pkg::COS_FRAC;
            ST_YC:   t0_reg <= prod + rbpw_pkg::RND_COS;
            ST_RX:   ry_reg <= (t0_reg + prod) >>> rbpw_pkg::COS_FRAC;
            ST_RY:   sx_reg <= rbpw_pkg::PROD_W'(ax_reg) + rx_reg + prod_rnd;
            ST_WZ:   sy_reg <= rbpw_pkg::PROD_W'(ay_reg) + ry_reg + prod_rnd;
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_x_reg   <= sat_x.value;
                    out_y_reg   <= sat_y.value;
                    out_z_reg   <= sat_z.value;
                    clipped_reg <= sat_x.clip || sat_y.clip || sat_z.clip;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign clipped   = clipped_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cor_rsp.done |-> (state_reg == ST_ROT))
        else $error("rotation finished outside the rotate state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && command) |=> (state_reg == ST_IDLE))
        else $error("seed transaction started a transform");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !command) |=> (state_reg == ST_SG))
        else $error("transform transaction not started");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && out_free) |=> (out_valid && (state_reg == ST_IDLE)))
        else $error("finished point not presented");

endmodule

// ===== hdl/rbpw_ring.sv =====
`timescale 1ns / 1ps

module rbpw_ring
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [rbpw_pkg::NOISE_W-1:0]        noise,
    output logic signed [rbpw_pkg::G_W-1:0]     g
);

    logic [rbpw_pkg::NOISE_W-1:0] ring_reg [4];
    logic [1:0]                   slot_reg;
    logic [rbpw_pkg::G_W:0]       sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ring_reg[i] <= rbpw_pkg::NOISE_RESET;
            end
            slot_reg <= 2'd0;
        end
        else if (push)
        begin
            ring_reg[slot_reg] <= noise;
            slot_reg           <= slot_reg + 2'd1;
        end
    end

    assign sum = (rbpw_pkg::G_W + 1)'(ring_reg[0]) + (rbpw_pkg::G_W + 1)'(ring_reg[1])
               + (rbpw_pkg::G_W + 1)'(ring_reg[2]) + (rbpw_pkg::G_W + 1)'(ring_reg[3]);

    // sum of four samples less 2.0 in Q.16
    assign g = rbpw_pkg::G_W'(sum - rbpw_pkg::NOISE_BIAS);

endmodule

// ===== hdl/rbpw_mul.sv =====
`timescale 1ns / 1ps

module rbpw_mul
(
    input  logic                  clk,
    input  rbpw_pkg::mul_op_t     a,
    input  rbpw_pkg::mul_op_t     b,
    output rbpw_pkg::prod_t       prod
);

    rbpw_pkg::prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/rbpw_cordic.sv =====
`timescale 1ns / 1ps

module rbpw_cordic
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rbpw_pkg::cordic_req_t     req,
    output rbpw_pkg::cordic_rsp_t     rsp
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [rbpw_pkg::CNT_W-1:0]   iter_reg;
    logic                         flip_reg;
    rbpw_pkg::cor_t               x_reg;
    rbpw_pkg::cor_t               y_reg;
    rbpw_pkg::cor_t               z_reg;
    rbpw_pkg::mul_op_t            cos_reg;
    rbpw_pkg::mul_op_t            sin_reg;

    logic                         flip_next;
    logic [31:0]                  angle_red;
    rbpw_pkg::cor_t               dx;
    rbpw_pkg::cor_t               dy;
    rbpw_pkg::cor_t               at;
    rbpw_pkg::cor_t               x_next;
    rbpw_pkg::cor_t               y_next;
    rbpw_pkg::cor_t               z_next;
    logic                         last;

    // second and third quarter turn: rotate by half a turn, negate at the end
    assign flip_next = (req.angle[31:30] == 2'b01) || (req.angle[31:30] == 2'b10);
    assign angle_red = flip_next ? (req.angle + rbpw_pkg::HALF_TURN) : req.angle;

    assign dx   = y_reg >>> iter_reg;
    assign dy   = x_reg >>> iter_reg;
    assign at   = rbpw_pkg::COR_W'(rbpw_pkg::ATAN_TURNS[rbpw_pkg::ATAN_IDX_W'(iter_reg)]);
    assign last = (iter_reg == rbpw_pkg::CNT_W'(rbpw_pkg::CORDIC_ITERS - 1));

    always_comb
    begin
        if (!z_reg[rbpw_pkg::COR_W-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + rbpw_pkg::CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            flip_reg <= flip_next;
            x_reg    <= rbpw_pkg::COR_W'(rbpw_pkg::CORDIC_K);
            y_reg    <= '0;
            z_reg    <= rbpw_pkg::COR_W'(signed'(angle_red));
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (last)
            begin
                cos_reg <= rbpw_pkg::MUL_W'(flip_reg ? -x_next : x_next);
                sin_reg <= rbpw_pkg::MUL_W'(flip_reg ? -y_next : y_next);
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.cos_val = cos_reg;
    assign rsp.sin_val = sin_reg;

endmodule
